@@ hw/rtl/rr_path_select_with_pinning_unit_assert.svh @@
// Assertion macros used by the checker file of the path select unit
`ifndef RR_PATH_SELECT_WITH_PINNING_UNIT_ASSERT_SVH
`define RR_PATH_SELECT_WITH_PINNING_UNIT_ASSERT_SVH

// antecedent and consequent in the same cycle
`define RRPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// consequent in the cycle after the antecedent
`define RRPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

@@ hw/rtl/rrps_pkg.sv @@
// Package: field widths, kind codes, defaults and state type of the path select unit
package rrps_pkg;

   localparam int FUNC_W = 3;
   localparam int ID_W   = 16;
   localparam int CNT_W  = 4;
   localparam int IDX_W  = 3;
   localparam int RR_W   = 32;

   localparam int MAX_PATHS_DEF   = 8;
   localparam int PIN_ENTRIES_DEF = 1024;

   localparam logic [FUNC_W-1:0] FUNC_RMA      = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_RDV_RMA  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_SEG_MID  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_SEG_LAST = 3'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

@@ hw/rtl/rrps_if.sv @@
// Request and response channel interfaces of the path select unit
interface rrps_req_if;
   logic                         valid;
   logic                         ready;
   logic [rrps_pkg::FUNC_W-1:0]  func;
   logic [rrps_pkg::ID_W-1:0]    msg_id;
   logic [rrps_pkg::CNT_W-1:0]   connected_paths;

   modport source (output valid, func, msg_id, connected_paths, input ready);
   modport sink   (input valid, func, msg_id, connected_paths, output ready);
   modport mon    (input valid, ready, func, msg_id, connected_paths);
endinterface

interface rrps_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [rrps_pkg::IDX_W-1:0]   path_index;
   logic                         spread_flag;

   modport source (output valid, path_index, spread_flag, input ready);
   modport sink   (input valid, path_index, spread_flag, output ready);
   modport mon    (input valid, ready, path_index, spread_flag);
endinterface

@@ hw/rtl/rr_path_select_with_pinning_unit.sv @@
// Top level: round-robin path select with message pinning, bit-serial modulo
//
// One request word per transmit operation on req_chan (func, msg_id, connected_paths)
// gives one response word on rsp_chan (path_index, spread_flag).
// Kinds rma and rendezvous rma, and pin misses, take 1 + count mod (paths - 1) from a
// 32-bit counter that advances with each pick; the modulo runs one counter bit per
// cycle through a shift register; no new request is taken until the response is loaded.
// Words that need no pick (pin hits, other kinds, one path or none) skip the modulo.
// A response word passes the read, modulo and final states (no modulo without a pick).
// The pin table has one read port and one write port; it is read at accept into a
// register for the read state, and written when the response is loaded.
// After reset the block sweeps the pin table clear, one entry per cycle, with
// req_chan.ready low until every entry is cleared; rsp_chan.valid is low throughout.
// The response sits in an output register: a new request is taken while it waits,
// and a stalled response holds; the next response waits in its final state until
// the register frees.
module rr_path_select_with_pinning_unit #(
   parameter int MAX_PATHS   = rrps_pkg::MAX_PATHS_DEF,
   parameter int PIN_ENTRIES = rrps_pkg::PIN_ENTRIES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   rrps_req_if.sink   req_chan,
   rrps_rsp_if.source rsp_chan
);

   localparam int CW      = rrps_pkg::CNT_W;
   localparam int AW      = $clog2(PIN_ENTRIES);
   localparam int PathW   = $clog2(MAX_PATHS);
   localparam int PIN_W   = (PathW < CW) ? PathW : CW;
   localparam int CntMax  = (1 << CW) - 1;
   localparam int CapInt  = (MAX_PATHS < CntMax) ? MAX_PATHS : CntMax;
   localparam int BitW    = $clog2(rrps_pkg::RR_W);

   localparam logic [CW-1:0]            CapPaths   = CW'(CapInt);
   localparam logic [rrps_pkg::ID_W:0]  TableLimit = (rrps_pkg::ID_W + 1)'(PIN_ENTRIES);
   localparam logic [AW-1:0]            LastEntry  = AW'(PIN_ENTRIES - 1);
   localparam logic [BitW-1:0]          LastBit    = BitW'(rrps_pkg::RR_W - 1);

   rrps_pkg::state_type state_ff, state_in;

   // pin table: valid bit over pin path
   logic [PIN_W:0] pin_mem [PIN_ENTRIES];
   logic [PIN_W:0] rd_ff;

   logic [AW-1:0]                 clr_ff, clr_in;
   logic [rrps_pkg::FUNC_W-1:0]   func_ff, func_in;
   logic [AW-1:0]                 addr_ff, addr_in;
   logic                          in_table_ff, in_table_in;
   logic [CW-1:0]                 eff_ff, eff_in;
   logic                          hit_ff, hit_in;
   logic [PIN_W-1:0]              pin_ff, pin_in;
   logic                          picked_ff, picked_in;
   logic [rrps_pkg::RR_W-1:0]     rr_ff, rr_in;
   logic [rrps_pkg::RR_W-1:0]     sh_ff, sh_in;
   logic [CW-1:0]                 rem_ff, rem_in;
   logic [CW-1:0]                 div_ff, div_in;
   logic [BitW-1:0]               bit_ff, bit_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [rrps_pkg::IDX_W-1:0]    idx_ff, idx_in;
   logic                          spread_ff, spread_in;

   logic           req_ready;
   logic           accept;
   logic           out_free;
   logic           out_load;
   logic           mem_we;
   logic [AW-1:0]  mem_wa;
   logic [PIN_W:0] mem_wd;
   logic           pick_go;
   logic           is_rr;
   logic           is_seg;
   logic [CW-1:0]  cp_eff;
   logic [CW:0]    trial;
   logic [CW-1:0]  pick_val;
   logic [CW-1:0]  demoted;
   logic [CW-1:0]  res_idx;
   logic           res_spread;
   logic           res_we;
   logic [PIN_W:0] res_wd;

   assign accept   = req_chan.valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign cp_eff   = (req_chan.connected_paths > CapPaths) ? CapPaths
                                                           : req_chan.connected_paths;

   // decision in the read cycle
   assign is_rr   = (func_ff == rrps_pkg::FUNC_RMA) || (func_ff == rrps_pkg::FUNC_RDV_RMA);
   assign is_seg  = (func_ff == rrps_pkg::FUNC_SEG_MID) || (func_ff == rrps_pkg::FUNC_SEG_LAST);
   assign hit_in  = in_table_ff && rd_ff[PIN_W];
   assign pin_in  = rd_ff[PIN_W-1:0];
   assign pick_go = (eff_ff > CW'(1)) && (is_rr || (is_seg && !hit_in));

   // one restoring step of the remainder per counter bit
   assign trial = {rem_ff, sh_ff[rrps_pkg::RR_W-1]};

   assign pick_val = picked_ff ? (rem_ff + CW'(1)) : '0;
   assign demoted  = (CW'(pin_ff) < eff_ff) ? CW'(pin_ff) : '0;

   always_comb begin
      res_idx    = '0;
      res_spread = 1'b1;
      res_we     = 1'b0;
      res_wd     = '0;
      case (func_ff)
         rrps_pkg::FUNC_RMA, rrps_pkg::FUNC_RDV_RMA: begin
            res_idx = pick_val;
         end
         rrps_pkg::FUNC_SEG_MID: begin
            if (hit_ff) begin
               res_idx = demoted;
            end else if (in_table_ff) begin
               res_idx = pick_val;
               res_we  = 1'b1;
               res_wd  = {1'b1, pick_val[PIN_W-1:0]};
            end else begin
               res_idx = '0;
            end
         end
         rrps_pkg::FUNC_SEG_LAST: begin
            if (hit_ff) begin
               res_idx = demoted;
               res_we  = 1'b1;
               res_wd  = '0;
            end else begin
               res_idx = pick_val;
            end
         end
         default: begin
            res_idx    = '0;
            res_spread = 1'b0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrps_pkg::ST_CLEAR: if (clr_ff == LastEntry) state_in = rrps_pkg::ST_IDLE;
         rrps_pkg::ST_IDLE:  if (accept) state_in = rrps_pkg::ST_READ;
         rrps_pkg::ST_READ:  state_in = pick_go ? rrps_pkg::ST_DIV : rrps_pkg::ST_DONE;
         rrps_pkg::ST_DIV:   if (bit_ff == LastBit) state_in = rrps_pkg::ST_DONE;
         rrps_pkg::ST_DONE:  if (out_free) state_in = rrps_pkg::ST_IDLE;
         default:            state_in = rrps_pkg::ST_CLEAR;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      out_load  = 1'b0;
      mem_we    = 1'b0;
      mem_wa    = addr_ff;
      mem_wd    = res_wd;
      case (state_ff)
         rrps_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = '0;
         end
         rrps_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         rrps_pkg::ST_DONE: begin
            out_load = out_free;
            mem_we   = out_free && res_we;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      clr_in       = (state_ff == rrps_pkg::ST_CLEAR) ? clr_ff + AW'(1) : clr_ff;
      func_in      = accept ? req_chan.func : func_ff;
      addr_in      = accept ? req_chan.msg_id[AW-1:0] : addr_ff;
      in_table_in  = accept ? ({1'b0, req_chan.msg_id} < TableLimit) : in_table_ff;
      eff_in       = accept ? cp_eff : eff_ff;
      picked_in    = picked_ff;
      sh_in        = sh_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      bit_in       = bit_ff;
      if (state_ff == rrps_pkg::ST_READ) begin
         picked_in = pick_go;
         sh_in     = rr_ff;
         rem_in    = '0;
         div_in    = eff_ff - CW'(1);
         bit_in    = '0;
      end else if (state_ff == rrps_pkg::ST_DIV) begin
         sh_in  = {sh_ff[rrps_pkg::RR_W-2:0], 1'b0};
         rem_in = (trial >= {1'b0, div_ff}) ? CW'(trial - {1'b0, div_ff}) : trial[CW-1:0];
         bit_in = bit_ff + BitW'(1);
      end
      rr_in        = (out_load && picked_ff) ? rr_ff + rrps_pkg::RR_W'(1) : rr_ff;
      rsp_valid_in = out_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
      idx_in       = out_load ? res_idx[rrps_pkg::IDX_W-1:0] : idx_ff;
      spread_in    = out_load ? res_spread : spread_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rrps_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rr_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rr_ff        <= rr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      addr_ff     <= addr_in;
      in_table_ff <= in_table_in;
      eff_ff      <= eff_in;
      if (state_ff == rrps_pkg::ST_READ) begin
         hit_ff <= hit_in;
         pin_ff <= pin_in;
      end
      picked_ff   <= picked_in;
      sh_ff       <= sh_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      bit_ff      <= bit_in;
      idx_ff      <= idx_in;
      spread_ff   <= spread_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         pin_mem[mem_wa] <= mem_wd;
      end
      rd_ff <= pin_mem[req_chan.msg_id[AW-1:0]];
   end

   assign req_chan.ready       = req_ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.path_index  = idx_ff;
   assign rsp_chan.spread_flag = spread_ff;

endmodule

@@ hw/rtl/rrps_check.sv @@
// Port checker of the path select unit and its bind to the top level
`include "rr_path_select_with_pinning_unit_assert.svh"

module rrps_check (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [rrps_pkg::IDX_W-1:0] rsp_path_index,
   input logic                       rsp_spread_flag
);

   logic                       rsp_stall;
   logic                       rsp_other;
   logic [rrps_pkg::IDX_W:0]   rsp_word;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_other = rsp_valid && !rsp_spread_flag;
   assign rsp_word  = {rsp_path_index, rsp_spread_flag};

   // stalled response word holds
   `RRPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_word))

   // kinds that are not spread always land on the primary path
   `RRPS_ASSERT_NOW(a_nospread_primary, clock, reset, rsp_other, rsp_path_index == '0)

   // one word in flight: ready drops right after an accept
   `RRPS_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)

   // reset starts the table sweep with nothing offered
   `RRPS_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !req_ready && !rsp_valid)

endmodule

bind rr_path_select_with_pinning_unit rrps_check u_rrps_check (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_path_index  (rsp_chan.path_index),
   .rsp_spread_flag (rsp_chan.spread_flag)
);
